// ----- hdl/cci_pkg.sv -----
// cci_pkg: types and constants for the circle collision impulse core.
// Request/result payload structs and pipeline stage records.
// No dependencies.
`default_nettype none

package cci_pkg;

    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 17;
    localparam int DIV_LAST    = DIV_STEPS;
    localparam int POST_FIRST  = DIV_STEPS + 1;
    localparam int POST_LAST   = DIV_STEPS + 8;
    localparam int PIPE_DEPTH  = 3 + SQRT_STEPS + 1 + DIV_STEPS + 8 + 1;

    localparam logic [16:0] FX_ONE  = 17'd65536;
    localparam logic [13:0] FX_PCT  = 14'd13107;
    localparam logic [9:0]  FX_SLOP = 10'd655;

    typedef struct packed {
        logic signed [31:0] rel_pos_x;
        logic signed [31:0] rel_pos_y;
        logic signed [31:0] rel_vel_x;
        logic signed [31:0] rel_vel_y;
        logic [30:0]        radius_sum;
        logic [30:0]        inv_mass_a;
        logic [30:0]        inv_mass_b;
        logic [16:0]        restitution_a;
        logic [16:0]        restitution_b;
    } request_t;

    typedef struct packed {
        logic               collided;
        logic               separating;
        logic signed [31:0] dvel_a_x;
        logic signed [31:0] dvel_a_y;
        logic signed [31:0] dvel_b_x;
        logic signed [31:0] dvel_b_y;
        logic signed [31:0] dpos_a_x;
        logic signed [31:0] dpos_a_y;
        logic signed [31:0] dpos_b_x;
        logic signed [31:0] dpos_b_y;
    } result_t;

    typedef struct packed {
        logic [31:0]        ax;
        logic [31:0]        ay;
        logic               sgnx;
        logic               sgny;
        logic               zero;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [30:0]        rsum;
        logic [16:0]        ra;
        logic [16:0]        rb;
        logic [30:0]        ima;
        logic [30:0]        imb;
        logic [31:0]        isum;
    } ctx_t;

    typedef struct packed {
        ctx_t         ctx;
        logic [63:0]  rem;
        logic [31:0]  root;
        logic [31:0]  warem;
        logic [16:0]  waq;
        logic [31:0]  wbrem;
        logic [16:0]  wbq;
    } sq_t;

    typedef struct packed {
        logic               coll;
        logic               mzero;
        logic               zero;
        logic               sgnx;
        logic               sgny;
        logic               lowx;
        logic               lowy;
        logic [31:0]        dlen;
        logic [31:0]        remx;
        logic [31:0]        remy;
        logic [16:0]        qx;
        logic [16:0]        qy;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [17:0]        onee;
        logic [16:0]        wa;
        logic [16:0]        wb;
        logic [30:0]        ex;
        logic [44:0]        cfull;
        logic [28:0]        c;
        logic signed [49:0] pvx;
        logic signed [49:0] pvy;
        logic signed [34:0] van;
        logic               sep;
        logic [45:0]        cafull;
        logic [45:0]        cbfull;
        logic [29:0]        ca;
        logic [29:0]        cb;
        logic signed [53:0] mfull;
        logic signed [37:0] m;
        logic signed [48:0] pa;
        logic signed [48:0] pay;
        logic signed [48:0] pb;
        logic signed [48:0] pby;
        logic signed [55:0] safull;
        logic signed [55:0] sbprod;
        logic signed [32:0] dp0;
        logic signed [32:0] dp1;
        logic signed [32:0] dp2;
        logic signed [32:0] dp3;
        logic signed [39:0] sa;
        logic signed [39:0] sb;
        logic signed [57:0] pv0;
        logic signed [57:0] pv1;
        logic signed [57:0] pv2;
        logic signed [57:0] pv3;
    } late_t;

endpackage

`default_nettype wire

// ----- hdl/circle_collision_impulse_core.sv -----
// circle_collision_impulse_core: pipelined Q16.16 impulse resolution for circle pairs.
// A done strobe follows each accepted request; one request per cycle,
// busy is always low. The pipeline holds a 32-stage square root and 17-stage dividers.
// Reset (async, active low) clears the valid chain; results carry no backpressure.
// Depends on cci_pkg.
`default_nettype none

module circle_collision_impulse_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire cci_pkg::request_t request,
    output logic                   done,
    output cci_pkg::result_t       result
);

    function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nb,
                                             input logic [31:0] d);
        logic [32:0] t;
        logic [32:0] r;
        begin
            t = {rem, nb};
            if (t >= {1'b0, d})
            begin
                r = t - {1'b0, d};
                div_step = {1'b1, r[31:0]};
            end
            else
            begin
                div_step = {1'b0, t[31:0]};
            end
        end
    endfunction

    function automatic logic [31:0] sat32(input logic signed [57:0] v);
        begin
            if (v[57:31] == {27{v[57]}})
                sat32 = v[31:0];
            else if (v[57])
                sat32 = 32'h8000_0000;
            else
                sat32 = 32'h7FFF_FFFF;
        end
    endfunction

    logic [cci_pkg::PIPE_DEPTH-1:0] vld_reg;

    cci_pkg::ctx_t  a_reg, a_next;
    cci_pkg::ctx_t  b_ctx_reg;
    logic [63:0]    b_sqx_reg, b_sqx_next;
    logic [63:0]    b_sqy_reg, b_sqy_next;
    cci_pkg::sq_t   sq_reg  [0:cci_pkg::SQRT_STEPS];
    cci_pkg::sq_t   sq_next [0:cci_pkg::SQRT_STEPS];
    cci_pkg::late_t lt_reg  [0:cci_pkg::POST_LAST];
    cci_pkg::late_t lt_next [0:cci_pkg::POST_LAST];
    cci_pkg::result_t res_reg, res_next;

    assign busy   = 1'b0;
    assign done   = vld_reg[cci_pkg::PIPE_DEPTH-1];
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[cci_pkg::PIPE_DEPTH-2:0], start};
    end

    // front: abs, squares, radicand
    always_comb
    begin
        a_next.sgnx = request.rel_pos_x[31];
        a_next.sgny = request.rel_pos_y[31];
        a_next.ax   = request.rel_pos_x[31] ? 32'(-request.rel_pos_x) : request.rel_pos_x;
        a_next.ay   = request.rel_pos_y[31] ? 32'(-request.rel_pos_y) : request.rel_pos_y;
        a_next.zero = (request.rel_pos_x == 32'sd0) && (request.rel_pos_y == 32'sd0);
        a_next.vx   = request.rel_vel_x;
        a_next.vy   = request.rel_vel_y;
        a_next.rsum = request.radius_sum;
        a_next.ra   = request.restitution_a;
        a_next.rb   = request.restitution_b;
        a_next.ima  = request.inv_mass_a;
        a_next.imb  = request.inv_mass_b;
        a_next.isum = {1'b0, request.inv_mass_a} + {1'b0, request.inv_mass_b};
    end

    assign b_sqx_next = a_reg.ax * a_reg.ax;
    assign b_sqy_next = a_reg.ay * a_reg.ay;

    always_comb
    begin
        sq_next[0].ctx   = b_ctx_reg;
        sq_next[0].rem   = b_sqx_reg + b_sqy_reg;
        sq_next[0].root  = '0;
        sq_next[0].warem = {2'b00, b_ctx_reg.ima[30:1]};
        sq_next[0].waq   = '0;
        sq_next[0].wbrem = {2'b00, b_ctx_reg.imb[30:1]};
        sq_next[0].wbq   = '0;
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_ctx_reg <= a_reg;
        b_sqx_reg <= b_sqx_next;
        b_sqy_reg <= b_sqy_next;
        sq_reg[0] <= sq_next[0];
    end

    // square root one bit per stage; weight division rides along
    for (genvar k = 0; k < cci_pkg::SQRT_STEPS; k++)
    begin : g_sqrt
        localparam int I = cci_pkg::SQRT_STEPS - 1 - k;
        logic [64:0] trial;
        logic [32:0] sa_res, sb_res;

        always_comb
        begin
            sq_next[k+1] = sq_reg[k];
            trial = ({33'b0, sq_reg[k].root} << (I + 1)) + (65'b1 << (2 * I));
            if ({1'b0, sq_reg[k].rem} >= trial)
            begin
                sq_next[k+1].rem     = sq_reg[k].rem - trial[63:0];
                sq_next[k+1].root[I] = 1'b1;
            end
            sa_res = div_step(sq_reg[k].warem, (k == 0) ? sq_reg[k].ctx.ima[0] : 1'b0,
                              sq_reg[k].ctx.isum);
            sb_res = div_step(sq_reg[k].wbrem, (k == 0) ? sq_reg[k].ctx.imb[0] : 1'b0,
                              sq_reg[k].ctx.isum);
            if (k < cci_pkg::DIV_STEPS)
            begin
                sq_next[k+1].warem = sa_res[31:0];
                sq_next[k+1].waq   = {sq_reg[k].waq[15:0], sa_res[32]};
                sq_next[k+1].wbrem = sb_res[31:0];
                sq_next[k+1].wbq   = {sq_reg[k].wbq[15:0], sb_res[32]};
            end
        end

        always_ff @(posedge clk)
        begin
            sq_reg[k+1] <= sq_next[k+1];
        end
    end

    // distance, overlap, penetration, normal division setup
    always_comb
    begin
        logic [31:0]        dlen;
        logic signed [33:0] exs;
        logic [16:0]        e;
        cci_pkg::sq_t       s;
        s    = sq_reg[cci_pkg::SQRT_STEPS];
        lt_next[0] = '0;
        dlen = s.ctx.zero ? 32'd1 : s.root;
        exs  = $signed({3'b000, s.ctx.rsum}) - $signed({2'b00, dlen})
             - $signed({24'b0, cci_pkg::FX_SLOP});
        e    = (s.ctx.ra < s.ctx.rb) ? s.ctx.ra : s.ctx.rb;
        if (e > cci_pkg::FX_ONE)
            e = cci_pkg::FX_ONE;
        lt_next[0].coll  = dlen < {1'b0, s.ctx.rsum};
        lt_next[0].mzero = (s.ctx.isum == 32'd0);
        lt_next[0].zero  = s.ctx.zero;
        lt_next[0].sgnx  = s.ctx.sgnx;
        lt_next[0].sgny  = s.ctx.sgny;
        lt_next[0].lowx  = s.ctx.ax[0];
        lt_next[0].lowy  = s.ctx.ay[0];
        lt_next[0].dlen  = dlen;
        lt_next[0].remx  = {1'b0, s.ctx.ax[31:1]};
        lt_next[0].remy  = {1'b0, s.ctx.ay[31:1]};
        lt_next[0].vx    = s.ctx.vx;
        lt_next[0].vy    = s.ctx.vy;
        lt_next[0].onee  = {1'b0, cci_pkg::FX_ONE} + {1'b0, e};
        lt_next[0].wa    = s.waq;
        lt_next[0].wb    = s.wbq;
        lt_next[0].ex    = exs[33] ? 31'd0 : exs[30:0];
    end

    for (genvar k = 0; k < cci_pkg::DIV_STEPS; k++)
    begin : g_ndiv
        logic [32:0] rx, ry;

        always_comb
        begin
            lt_next[k+1] = lt_reg[k];
            rx = div_step(lt_reg[k].remx, (k == 0) ? lt_reg[k].lowx : 1'b0, lt_reg[k].dlen);
            ry = div_step(lt_reg[k].remy, (k == 0) ? lt_reg[k].lowy : 1'b0, lt_reg[k].dlen);
            lt_next[k+1].remx = rx[31:0];
            lt_next[k+1].remy = ry[31:0];
            lt_next[k+1].qx   = {lt_reg[k].qx[15:0], rx[32]};
            lt_next[k+1].qy   = {lt_reg[k].qy[15:0], ry[32]};
        end
    end

    // normal vector, penetration scale
    always_comb
    begin
        cci_pkg::late_t s;
        s = lt_reg[cci_pkg::DIV_LAST];
        lt_next[cci_pkg::POST_FIRST] = s;
        if (s.zero)
        begin
            lt_next[cci_pkg::POST_FIRST].nx = $signed({1'b0, cci_pkg::FX_ONE});
            lt_next[cci_pkg::POST_FIRST].ny = '0;
        end
        else
        begin
            lt_next[cci_pkg::POST_FIRST].nx = s.sgnx ? -$signed({1'b0, s.qx})
                                                     : $signed({1'b0, s.qx});
            lt_next[cci_pkg::POST_FIRST].ny = s.sgny ? -$signed({1'b0, s.qy})
                                                     : $signed({1'b0, s.qy});
        end
        lt_next[cci_pkg::POST_FIRST].cfull = s.ex * cci_pkg::FX_PCT;
    end

    always_comb
    begin
        cci_pkg::late_t s;
        s = lt_reg[cci_pkg::POST_FIRST];
        lt_next[cci_pkg::POST_FIRST+1]     = s;
        lt_next[cci_pkg::POST_FIRST+1].pvx = s.vx * s.nx;
        lt_next[cci_pkg::POST_FIRST+1].pvy = s.vy * s.ny;
        lt_next[cci_pkg::POST_FIRST+1].c   = s.cfull[44:16];
    end

    always_comb
    begin
        cci_pkg::late_t     s;
        logic signed [50:0] sum;
        s   = lt_reg[cci_pkg::POST_FIRST+1];
        sum = s.pvx + s.pvy;
        lt_next[cci_pkg::POST_FIRST+2]        = s;
        lt_next[cci_pkg::POST_FIRST+2].van    = $signed(sum[50:16]);
        lt_next[cci_pkg::POST_FIRST+2].sep    = s.coll && !sum[50] && (sum[50:16] != '0);
        lt_next[cci_pkg::POST_FIRST+2].cafull = s.c * s.wa;
        lt_next[cci_pkg::POST_FIRST+2].cbfull = s.c * s.wb;
    end

    always_comb
    begin
        cci_pkg::late_t s;
        s = lt_reg[cci_pkg::POST_FIRST+2];
        lt_next[cci_pkg::POST_FIRST+3]       = s;
        lt_next[cci_pkg::POST_FIRST+3].mfull = $signed({1'b0, s.onee}) * s.van;
        lt_next[cci_pkg::POST_FIRST+3].ca    = s.cafull[45:16];
        lt_next[cci_pkg::POST_FIRST+3].cb    = s.cbfull[45:16];
    end

    always_comb
    begin
        cci_pkg::late_t s;
        s = lt_reg[cci_pkg::POST_FIRST+3];
        lt_next[cci_pkg::POST_FIRST+4]     = s;
        lt_next[cci_pkg::POST_FIRST+4].m   = $signed(s.mfull[53:16]);
        lt_next[cci_pkg::POST_FIRST+4].pa  = $signed({1'b0, s.ca}) * s.nx;
        lt_next[cci_pkg::POST_FIRST+4].pay = $signed({1'b0, s.ca}) * s.ny;
        lt_next[cci_pkg::POST_FIRST+4].pb  = $signed({1'b0, s.cb}) * s.nx;
        lt_next[cci_pkg::POST_FIRST+4].pby = $signed({1'b0, s.cb}) * s.ny;
    end

    always_comb
    begin
        cci_pkg::late_t     s;
        logic signed [48:0] na, nay;
        s   = lt_reg[cci_pkg::POST_FIRST+4];
        na  = -s.pa;
        nay = -s.pay;
        lt_next[cci_pkg::POST_FIRST+5]        = s;
        lt_next[cci_pkg::POST_FIRST+5].safull = s.m * $signed({1'b0, s.wa});
        lt_next[cci_pkg::POST_FIRST+5].sbprod = s.m * $signed({1'b0, s.wb});
        lt_next[cci_pkg::POST_FIRST+5].dp0    = $signed(na[48:16]);
        lt_next[cci_pkg::POST_FIRST+5].dp1    = $signed(nay[48:16]);
        lt_next[cci_pkg::POST_FIRST+5].dp2    = $signed(s.pb[48:16]);
        lt_next[cci_pkg::POST_FIRST+5].dp3    = $signed(s.pby[48:16]);
    end

    always_comb
    begin
        cci_pkg::late_t     s;
        logic signed [55:0] nb;
        s  = lt_reg[cci_pkg::POST_FIRST+5];
        nb = -s.sbprod;
        lt_next[cci_pkg::POST_FIRST+6]    = s;
        lt_next[cci_pkg::POST_FIRST+6].sa = $signed(s.safull[55:16]);
        lt_next[cci_pkg::POST_FIRST+6].sb = $signed(nb[55:16]);
    end

    always_comb
    begin
        cci_pkg::late_t s;
        s = lt_reg[cci_pkg::POST_FIRST+6];
        lt_next[cci_pkg::POST_LAST]     = s;
        lt_next[cci_pkg::POST_LAST].pv0 = s.sa * s.nx;
        lt_next[cci_pkg::POST_LAST].pv1 = s.sa * s.ny;
        lt_next[cci_pkg::POST_LAST].pv2 = s.sb * s.nx;
        lt_next[cci_pkg::POST_LAST].pv3 = s.sb * s.ny;
    end

    for (genvar k = 0; k <= cci_pkg::POST_LAST; k++)
    begin : g_late
        always_ff @(posedge clk)
        begin
            lt_reg[k] <= lt_next[k];
        end
    end

    // final shift, saturate, gate
    always_comb
    begin
        cci_pkg::late_t s;
        logic           act, vel;
        s   = lt_reg[cci_pkg::POST_LAST];
        act = s.coll && !s.mzero;
        vel = act && !s.sep;
        res_next.collided   = s.coll;
        res_next.separating = s.sep;
        res_next.dvel_a_x = vel ? sat32(58'($signed(s.pv0[57:16]))) : '0;
        res_next.dvel_a_y = vel ? sat32(58'($signed(s.pv1[57:16]))) : '0;
        res_next.dvel_b_x = vel ? sat32(58'($signed(s.pv2[57:16]))) : '0;
        res_next.dvel_b_y = vel ? sat32(58'($signed(s.pv3[57:16]))) : '0;
        res_next.dpos_a_x = act ? sat32(58'(s.dp0)) : '0;
        res_next.dpos_a_y = act ? sat32(58'(s.dp1)) : '0;
        res_next.dpos_b_x = act ? sat32(58'(s.dp2)) : '0;
        res_next.dpos_b_y = act ? sat32(58'(s.dp3)) : '0;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// tb: self-checking bench for circle_collision_impulse_core. Depends on cci_pkg.
// Drives collision requests from a directed table and random pairs, predicts each
// result in Q16.16 unless its table row gives it; compares it on the done strobe.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE   = 80;
    localparam int WATCHDOG = 5000;
    localparam int N_RANDOM = 1200;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    cci_pkg::request_t request;
    logic              done;
    cci_pkg::result_t  result;

    circle_collision_impulse_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cci_pkg::result_t pending_results[$];
    int      errors;
    int      idle_cycles;
    int      send_idle_pct;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7fffffff;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic cci_pkg::result_t resolve_pair(cci_pkg::request_t q);
        cci_pkg::result_t r;
        longint px, py, vx, vy, rsum, ima, imb, ra, rb;
        longint dlen, nx, ny, van, e, isum, wa, wb, m, sa, sb, ex, c, ca, cb;
        logic [63:0] ax, ay;
        px = longint'(q.rel_pos_x);
        py = longint'(q.rel_pos_y);
        vx = longint'(q.rel_vel_x);
        vy = longint'(q.rel_vel_y);
        rsum = longint'({1'b0, q.radius_sum});
        ima = longint'({1'b0, q.inv_mass_a});
        imb = longint'({1'b0, q.inv_mass_b});
        ra = longint'({1'b0, q.restitution_a});
        rb = longint'({1'b0, q.restitution_b});
        r = '0;
        if (px == 0 && py == 0)
        begin
            nx = 65536;
            ny = 0;
            dlen = 1;
        end
        else
        begin
            ax = px < 0 ? -px : px;
            ay = py < 0 ? -py : py;
            dlen = longint'(root_floor(ax * ax + ay * ay));
            nx = (px * 65536) / dlen;
            ny = (py * 65536) / dlen;
        end
        if (dlen >= rsum)
            return r;
        van = floor_shift(vx * nx + vy * ny, 16);
        r.collided = 1'b1;
        r.separating = van > 0;
        isum = ima + imb;
        if (isum == 0)
            return r;
        wa = (ima * 65536) / isum;
        wb = (imb * 65536) / isum;
        if (!r.separating)
        begin
            e = ra < rb ? ra : rb;
            if (e > 65536)
                e = 65536;
            m = floor_shift((65536 + e) * van, 16);
            sa = floor_shift(m * wa, 16);
            sb = floor_shift(-(m * wb), 16);
            r.dvel_a_x = clamp32(floor_shift(sa * nx, 16));
            r.dvel_a_y = clamp32(floor_shift(sa * ny, 16));
            r.dvel_b_x = clamp32(floor_shift(sb * nx, 16));
            r.dvel_b_y = clamp32(floor_shift(sb * ny, 16));
        end
        ex = rsum - dlen - 655;
        if (ex < 0)
            ex = 0;
        c = floor_shift(ex * 13107, 16);
        ca = floor_shift(c * wa, 16);
        cb = floor_shift(c * wb, 16);
        r.dpos_a_x = clamp32(floor_shift(-(ca * nx), 16));
        r.dpos_a_y = clamp32(floor_shift(-(ca * ny), 16));
        r.dpos_b_x = clamp32(floor_shift(cb * nx, 16));
        r.dpos_b_y = clamp32(floor_shift(cb * ny, 16));
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 16'hffff)) - 32'sd32768);
            2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            3: return 32'($signed($urandom_range(0, 24'hffffff)) - 32'sd8388608);
            4: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 20'hfffff)) - 32'sd524288);
        endcase
    endfunction

    function automatic logic [30:0] rand_mag();
        case ($urandom_range(0, 4))
            0: return 31'($urandom);
            1: return 31'($urandom_range(0, 24'hffffff));
            2: return 31'($urandom_range(0, 1)) * 31'($urandom_range(0, 20'h3ffff));
            3: return 31'($urandom_range(0, 20'hfffff));
            default: return 31'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    function automatic cci_pkg::request_t rand_pair();
        cci_pkg::request_t q;
        logic [31:0] px, py;
        px = rand_word();
        py = rand_word();
        q.rel_pos_x = px;
        q.rel_pos_y = py;
        q.rel_vel_x = rand_word();
        q.rel_vel_y = rand_word();
        q.inv_mass_a = rand_mag();
        q.inv_mass_b = rand_mag();
        q.restitution_a = 17'($urandom);
        q.restitution_b = $urandom_range(0, 3) == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536));
        if ($urandom_range(0, 3) != 0)
            q.radius_sum = 31'($urandom_range(0, 1) ? 32'h7fffffff : 32'($urandom_range(0, 16'hffff)) +
                $urandom_range(0, 32'h3fffffff));
        else
            q.radius_sum = 31'($urandom);
        return q;
    endfunction

    task automatic send_request(cci_pkg::request_t q, logic has_answer,
        cci_pkg::result_t answer);
        while ($urandom_range(1, 100) <= send_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        request <= q;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(has_answer ? answer : resolve_pair(q));
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no request waiting: %h", $time, result);
                end
                else if (pending_results[0] !== result)
                begin
                    errors++;
                    $display("%0t: mismatch expected %h actual %h", $time,
                        pending_results[0], result);
                    void'(pending_results.pop_front());
                end
                else
                    void'(pending_results.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    cci_pkg::request_t table_req[$];
    logic              table_has[$];
    cci_pkg::result_t  table_res[$];

    task automatic add_row(logic [31:0] px, logic [31:0] py, logic [31:0] vx, logic [31:0] vy,
        logic [30:0] rs, logic [30:0] ma, logic [30:0] mb, logic [16:0] ea, logic [16:0] eb,
        logic has, cci_pkg::result_t res);
        cci_pkg::request_t q;
        q = '{px, py, vx, vy, rs, ma, mb, ea, eb};
        table_req.push_back(q);
        table_has.push_back(has);
        table_res.push_back(res);
    endtask

    initial
    begin
        cci_pkg::result_t none;
        cci_pkg::result_t coll_only;
        errors = 0;
        idle_cycles = 0;
        send_idle_pct = 26;
        none = '0;
        coll_only = '0;
        coll_only.collided = 1'b1;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        // no overlap, both immovable, extremes
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, none);
        add_row(32'h7fffffff, 32'h7fffffff, 0, 0, 31'h7fffffff, 1, 1, 0, 0, 1, none);
        add_row(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 31'h7fffffff,
            31'h7fffffff, 31'h7fffffff, 17'h1ffff, 17'h1ffff, 0, none);
        add_row(0, 0, 0, 0, 31'h10000, 0, 0, 65536, 65536, 1, coll_only);
        add_row(32'h10000, 0, 32'hffff0000, 0, 31'h20000, 0, 0, 0, 0, 1, coll_only);
        // coincident centres
        add_row(0, 0, 32'hfff00000, 32'h00100000, 31'h20000, 31'h10000, 31'h10000, 65536, 65536,
            0, none);
        add_row(0, 0, 32'h7fffffff, 32'h80000000, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
            17'h1ffff, 17'h1ffff, 0, none);
        // approaching, separating, one immovable, restitution above one
        add_row(32'h10000, 32'h10000, 32'hfffe0000, 32'hffff0000, 31'h30000, 31'h10000, 0,
            32768, 65536, 0, none);
        add_row(32'h10000, 32'h10000, 32'h20000, 32'h10000, 31'h30000, 0, 31'h10000,
            0, 0, 0, none);
        add_row(32'hffff0000, 32'h8000, 32'h30000, 32'h0, 31'h20000, 31'h8000, 31'h18000,
            17'h1ffff, 17'h1ffff, 0, none);
        add_row(32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 31'h7fffffff, 1,
            65536, 65536, 0, none);
        add_row(1, 0, 32'h80000000, 0, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 65536, 65536,
            0, none);
        add_row(32'h100, 32'hffffff00, 32'h10000, 32'h10000, 31'h300, 31'h7fffffff, 0, 0, 65535,
            0, none);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (table_req[i])
            send_request(table_req[i], table_has[i], table_res[i]);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 3)
                send_idle_pct = 79;
            else if (i == 2 * N_RANDOM / 3)
                send_idle_pct = 0;
            send_request(rand_pair(), 1'b0, none);
        end
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

`default_nettype wire
